### design/task_pool_frame_scheduler_defines.svh
// Assertion helpers used by the scheduler datapath module.
`ifndef TASK_POOL_FRAME_SCHEDULER_DEFINES_SVH
`define TASK_POOL_FRAME_SCHEDULER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TPFS_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");
`define TPFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");
`else
`define TPFS_ASSERT_IMPLIES(lbl, ante, cons)
`define TPFS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### design/tpfs_pkg.sv
package tpfs_pkg;

    localparam int SLOT_W = 6;
    localparam int HND_W = 32;
    localparam int WT_W = 16;
    localparam int RESULT_CAP = 64;
    localparam int CNT_W = 7;

    localparam logic [3:0] OP_INIT = 4'd0;
    localparam logic [3:0] OP_CREATE = 4'd1;
    localparam logic [3:0] OP_KILL = 4'd2;
    localparam logic [3:0] OP_CALL = 4'd3;
    localparam logic [3:0] OP_RETURN = 4'd4;
    localparam logic [3:0] OP_SET_WAIT = 4'd5;
    localparam logic [3:0] OP_SLEEP = 4'd6;
    localparam logic [3:0] OP_WAKEUP = 4'd7;
    localparam logic [3:0] OP_TICK = 4'd8;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_NOT_USED = 2'd2;

    localparam logic KIND_ACK = 1'b0;
    localparam logic KIND_DISPATCH = 1'b1;

    typedef struct packed {
        logic [3:0]        op;
        logic [SLOT_W-1:0] slot;
        logic [HND_W-1:0]  entry_addr;
        logic [WT_W-1:0]   wait_time;
    } in_t;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] task_slot;
        logic [HND_W-1:0]  handler;
        logic [1:0]        status;
        logic              dispatch_valid;
        logic              last;
    } out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_CREATE2,
        S_KILL,
        S_TICK_CHK,
        S_TICK_EVAL,
        S_TICK_END,
        S_ACK_OK,
        S_ACK_FULL,
        S_ACK_FREE
    } state_t;

    typedef enum logic [3:0] {
        C_NONE,
        C_LOAD,
        C_INIT,
        C_SCAN_START,
        C_SCAN_STEP,
        C_CREATE,
        C_CREATE2,
        C_KILL,
        C_SETW,
        C_FLAG,
        C_TICK_START,
        C_TEVAL,
        C_TEND,
        C_ACK
    } cmd_t;

    typedef struct packed {
        cmd_t       op;
        logic       rd_slot;
        logic [1:0] status;
    } cmd_bus_t;

    typedef struct packed {
        logic [3:0] op;
        logic       live;
        logic       slot_ok;
        logic       scan_free;
        logic       scan_last;
        logic       cur_none;
        logic       out_free;
        logic       push_block;
    } stat_bus_t;

endpackage

### design/tpfs_ram.sv
module tpfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### design/tpfs_dp.sv
`include "task_pool_frame_scheduler_defines.svh"
module tpfs_dp #(
    parameter int TASK_SLOTS = 64,
    parameter int WAIT_BITS = 16,
    parameter int ADDR_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tpfs_pkg::in_t       item,
    input  tpfs_pkg::cmd_bus_t  cmd,
    output tpfs_pkg::stat_bus_t stat,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output tpfs_pkg::out_t      rsp_item
);
    import tpfs_pkg::*;

    localparam int IW = $clog2(TASK_SLOTS);
    localparam int SW = $clog2(TASK_SLOTS + 1);
    localparam int CW = (SW > SLOT_W) ? SW : SLOT_W;
    localparam logic [SW-1:0] NONE = SW'(TASK_SLOTS);
    localparam logic [SW-1:0] LASTI = SW'(TASK_SLOTS - 1);

    logic [3:0]            op_reg, op_next;
    logic [IW-1:0]         slot_reg, slot_next;
    logic                  slot_ok_reg, slot_ok_next;
    logic [ADDR_BITS-1:0]  addr_reg, addr_next;
    logic [WAIT_BITS-1:0]  wait_reg, wait_next;
    logic [TASK_SLOTS-1:0] use_reg, use_next;
    logic [TASK_SLOTS-1:0] sleep_reg, sleep_next;
    logic [TASK_SLOTS-1:0] wv_reg, wv_next;
    logic [TASK_SLOTS-1:0] pv_reg, pv_next;
    logic [SW-1:0]         head_reg, head_next;
    logic [SW-1:0]         tail_reg, tail_next;
    logic [SW-1:0]         scan_reg, scan_next;
    logic [SLOT_W-1:0]     ackslot_reg, ackslot_next;
    logic [CNT_W-1:0]      dcnt_reg, dcnt_next;
    logic                  pend_vld_reg, pend_vld_next;
    logic [SLOT_W-1:0]     pend_slot_reg, pend_slot_next;
    logic [HND_W-1:0]      pend_hnd_reg, pend_hnd_next;
    logic                  out_vld_reg, out_vld_next;
    out_t                  out_reg, out_next;

    logic [IW-1:0]         scan_ix, raddr;
    logic [ADDR_BITS-1:0]  hnd_q;
    logic [WAIT_BITS-1:0]  wait_q, wcur;
    logic [SW-1:0]         par_q, prev_q, next_q, par;
    logic                  h_we, w_we, pa_we, pr_we, nx_we;
    logic [IW-1:0]         h_wa, w_wa, pa_wa, pr_wa, nx_wa;
    logic [WAIT_BITS-1:0]  w_wd;
    logic [SW-1:0]         pa_wd, pr_wd, nx_wd;
    logic                  awake, dec, disp, out_free, push_en;
    out_t                  push_data;

    assign scan_ix = scan_reg[IW-1:0];
    assign raddr = cmd.rd_slot ? slot_reg : scan_ix;
    assign out_free = !out_vld_reg || !rsp_stall;
    assign wcur = wv_reg[scan_ix] ? wait_q : '0;
    assign awake = !sleep_reg[scan_ix];
    assign dec = awake && (wcur > WAIT_BITS'(1));
    assign disp = awake && !(wcur > WAIT_BITS'(1)) && (dcnt_reg < CNT_W'(RESULT_CAP));
    assign par = pv_reg[slot_reg] ? par_q : NONE;

    always_comb
    begin
        stat.op = op_reg;
        stat.slot_ok = slot_ok_reg;
        stat.live = slot_ok_reg && use_reg[slot_reg];
        stat.scan_free = !use_reg[scan_ix];
        stat.scan_last = (scan_reg == LASTI);
        stat.cur_none = (scan_reg == NONE);
        stat.out_free = out_free;
        stat.push_block = disp && pend_vld_reg && !out_free;
    end

    always_comb
    begin
        op_next = op_reg;
        slot_next = slot_reg;
        slot_ok_next = slot_ok_reg;
        addr_next = addr_reg;
        wait_next = wait_reg;
        use_next = use_reg;
        sleep_next = sleep_reg;
        wv_next = wv_reg;
        pv_next = pv_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        scan_next = scan_reg;
        ackslot_next = ackslot_reg;
        dcnt_next = dcnt_reg;
        pend_vld_next = pend_vld_reg;
        pend_slot_next = pend_slot_reg;
        pend_hnd_next = pend_hnd_reg;
        h_we = 1'b0;
        h_wa = scan_ix;
        w_we = 1'b0;
        w_wa = scan_ix;
        w_wd = wcur - WAIT_BITS'(1);
        pa_we = 1'b0;
        pa_wa = scan_ix;
        pa_wd = (op_reg == OP_CALL) ? SW'(slot_reg) : NONE;
        pr_we = 1'b0;
        pr_wa = scan_ix;
        pr_wd = NONE;
        nx_we = 1'b0;
        nx_wa = scan_ix;
        nx_wd = NONE;
        push_en = 1'b0;
        push_data = '{kind: KIND_ACK, task_slot: ackslot_reg, handler: '0,
                      status: cmd.status, dispatch_valid: 1'b0, last: 1'b1};
        case (cmd.op)
            C_LOAD:
            begin
                op_next = item.op;
                slot_next = IW'(item.slot);
                slot_ok_next = CW'(item.slot) < CW'(TASK_SLOTS);
                addr_next = ADDR_BITS'(item.entry_addr);
                wait_next = WAIT_BITS'(item.wait_time);
                ackslot_next = '0;
            end
            C_INIT:
            begin
                use_next = '0;
                sleep_next = '0;
                head_next = NONE;
                tail_next = NONE;
            end
            C_SCAN_START:
            begin
                scan_next = '0;
            end
            C_SCAN_STEP:
            begin
                scan_next = scan_reg + SW'(1);
            end
            C_CREATE:
            begin
                use_next[scan_ix] = 1'b1;
                sleep_next[scan_ix] = 1'b0;
                pv_next[scan_ix] = 1'b1;
                h_we = 1'b1;
                pa_we = 1'b1;
                pr_we = 1'b1;
                if (head_reg == NONE)
                begin
                    head_next = scan_reg;
                end
                else
                begin
                    pr_wd = tail_reg;
                    nx_we = 1'b1;
                    nx_wa = tail_reg[IW-1:0];
                    nx_wd = scan_reg;
                end
                tail_next = scan_reg;
            end
            C_CREATE2:
            begin
                nx_we = 1'b1;
                ackslot_next = SLOT_W'(scan_reg);
                if (op_reg == OP_CALL)
                begin
                    sleep_next[slot_reg] = 1'b1;
                end
            end
            C_KILL:
            begin
                if ((op_reg == OP_RETURN) && (par != NONE) && use_reg[par[IW-1:0]])
                begin
                    sleep_next[par[IW-1:0]] = 1'b0;
                end
                use_next[slot_reg] = 1'b0;
                if ((prev_q == NONE) && (next_q == NONE))
                begin
                    use_next = '0;
                    sleep_next = '0;
                    head_next = NONE;
                    tail_next = NONE;
                end
                else
                begin
                    if (prev_q == NONE)
                    begin
                        head_next = next_q;
                    end
                    else
                    begin
                        nx_we = 1'b1;
                        nx_wa = prev_q[IW-1:0];
                        nx_wd = next_q;
                    end
                    if (next_q == NONE)
                    begin
                        tail_next = prev_q;
                    end
                    else
                    begin
                        pr_we = 1'b1;
                        pr_wa = next_q[IW-1:0];
                        pr_wd = prev_q;
                    end
                end
            end
            C_SETW:
            begin
                w_we = 1'b1;
                w_wa = slot_reg;
                w_wd = wait_reg;
                wv_next[slot_reg] = 1'b1;
            end
            C_FLAG:
            begin
                sleep_next[slot_reg] = (op_reg == OP_SLEEP);
            end
            C_TICK_START:
            begin
                scan_next = head_reg;
                dcnt_next = '0;
                pend_vld_next = 1'b0;
            end
            C_TEVAL:
            begin
                w_we = dec;
                if (disp)
                begin
                    push_en = pend_vld_reg;
                    push_data = '{kind: KIND_DISPATCH, task_slot: pend_slot_reg,
                                  handler: pend_hnd_reg, status: ST_OK,
                                  dispatch_valid: 1'b1, last: 1'b0};
                    pend_vld_next = 1'b1;
                    pend_slot_next = SLOT_W'(scan_reg);
                    pend_hnd_next = HND_W'(hnd_q);
                    dcnt_next = dcnt_reg + CNT_W'(1);
                end
                scan_next = next_q;
            end
            C_TEND:
            begin
                push_en = 1'b1;
                if (pend_vld_reg)
                begin
                    push_data = '{kind: KIND_DISPATCH, task_slot: pend_slot_reg,
                                  handler: pend_hnd_reg, status: ST_OK,
                                  dispatch_valid: 1'b1, last: 1'b1};
                end
                else
                begin
                    push_data = '{kind: KIND_ACK, task_slot: '0, handler: '0,
                                  status: ST_OK, dispatch_valid: 1'b0, last: 1'b1};
                end
                pend_vld_next = 1'b0;
            end
            C_ACK:
            begin
                push_en = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        out_next = out_reg;
        if (push_en)
        begin
            out_vld_next = 1'b1;
            out_next = push_data;
        end
        else if (out_vld_reg && !rsp_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_reg <= '0;
            sleep_reg <= '0;
            wv_reg <= '0;
            pv_reg <= '0;
            head_reg <= NONE;
            tail_reg <= NONE;
            scan_reg <= NONE;
            dcnt_reg <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            use_reg <= use_next;
            sleep_reg <= sleep_next;
            wv_reg <= wv_next;
            pv_reg <= pv_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            scan_reg <= scan_next;
            dcnt_reg <= dcnt_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        slot_reg <= slot_next;
        slot_ok_reg <= slot_ok_next;
        addr_reg <= addr_next;
        wait_reg <= wait_next;
        ackslot_reg <= ackslot_next;
        pend_slot_reg <= pend_slot_next;
        pend_hnd_reg <= pend_hnd_next;
        out_reg <= out_next;
    end

    tpfs_ram #(.WIDTH(ADDR_BITS), .DEPTH(TASK_SLOTS)) u_hnd_ram (
        .clk(clk), .we(h_we), .waddr(h_wa), .wdata(addr_reg), .raddr(raddr), .rdata(hnd_q)
    );
    tpfs_ram #(.WIDTH(WAIT_BITS), .DEPTH(TASK_SLOTS)) u_wait_ram (
        .clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(raddr), .rdata(wait_q)
    );
    tpfs_ram #(.WIDTH(SW), .DEPTH(TASK_SLOTS)) u_par_ram (
        .clk(clk), .we(pa_we), .waddr(pa_wa), .wdata(pa_wd), .raddr(raddr), .rdata(par_q)
    );
    tpfs_ram #(.WIDTH(SW), .DEPTH(TASK_SLOTS)) u_prev_ram (
        .clk(clk), .we(pr_we), .waddr(pr_wa), .wdata(pr_wd), .raddr(raddr), .rdata(prev_q)
    );
    tpfs_ram #(.WIDTH(SW), .DEPTH(TASK_SLOTS)) u_next_ram (
        .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(raddr), .rdata(next_q)
    );

    assign rsp_valid = out_vld_reg;
    assign rsp_item = out_reg;

    `TPFS_ASSERT_IMPLIES(a_head_tail_empty, head_reg == NONE, tail_reg == NONE)
    `TPFS_ASSERT_IMPLIES(a_dispatch_cap, 1'b1, dcnt_reg <= CNT_W'(RESULT_CAP))
    `TPFS_ASSERT_IMPLIES(a_push_room, push_en, out_free)
endmodule

### design/tpfs_ctrl.sv
module tpfs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  tpfs_pkg::stat_bus_t stat,
    output tpfs_pkg::cmd_bus_t  cmd
);
    import tpfs_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.op)
                    OP_INIT: state_next = S_ACK_OK;
                    OP_CREATE: state_next = S_SCAN;
                    OP_CALL: state_next = stat.live ? S_SCAN : S_ACK_FREE;
                    OP_KILL, OP_RETURN: state_next = stat.live ? S_KILL : S_ACK_FREE;
                    OP_SET_WAIT: state_next = stat.slot_ok ? S_ACK_OK : S_ACK_FREE;
                    OP_SLEEP, OP_WAKEUP: state_next = stat.live ? S_ACK_OK : S_ACK_FREE;
                    OP_TICK: state_next = S_TICK_CHK;
                    default: state_next = S_ACK_OK;
                endcase
            end
            S_SCAN:
            begin
                if (stat.scan_free)
                begin
                    state_next = S_CREATE2;
                end
                else if (stat.scan_last)
                begin
                    state_next = S_ACK_FULL;
                end
            end
            S_CREATE2: state_next = S_ACK_OK;
            S_KILL: state_next = S_ACK_OK;
            S_TICK_CHK: state_next = stat.cur_none ? S_TICK_END : S_TICK_EVAL;
            S_TICK_EVAL:
            begin
                if (!stat.push_block)
                begin
                    state_next = S_TICK_CHK;
                end
            end
            S_TICK_END, S_ACK_OK, S_ACK_FULL, S_ACK_FREE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op = C_NONE;
        cmd.rd_slot = 1'b0;
        cmd.status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd.op = C_LOAD;
                end
            end
            S_DECODE:
            begin
                cmd.rd_slot = 1'b1;
                case (stat.op)
                    OP_INIT: cmd.op = C_INIT;
                    OP_CREATE: cmd.op = C_SCAN_START;
                    OP_CALL: cmd.op = stat.live ? C_SCAN_START : C_NONE;
                    OP_SET_WAIT: cmd.op = stat.slot_ok ? C_SETW : C_NONE;
                    OP_SLEEP, OP_WAKEUP: cmd.op = stat.live ? C_FLAG : C_NONE;
                    OP_TICK: cmd.op = C_TICK_START;
                    default: cmd.op = C_NONE;
                endcase
            end
            S_SCAN: cmd.op = stat.scan_free ? C_CREATE : (stat.scan_last ? C_NONE : C_SCAN_STEP);
            S_CREATE2: cmd.op = C_CREATE2;
            S_KILL:
            begin
                cmd.rd_slot = 1'b1;
                cmd.op = C_KILL;
            end
            S_TICK_EVAL: cmd.op = stat.push_block ? C_NONE : C_TEVAL;
            S_TICK_END: cmd.op = stat.out_free ? C_TEND : C_NONE;
            S_ACK_OK: cmd.op = stat.out_free ? C_ACK : C_NONE;
            S_ACK_FULL:
            begin
                cmd.op = stat.out_free ? C_ACK : C_NONE;
                cmd.status = ST_NO_FREE;
            end
            S_ACK_FREE:
            begin
                cmd.op = stat.out_free ? C_ACK : C_NONE;
                cmd.status = ST_NOT_USED;
            end
            default: cmd.op = C_NONE;
        endcase
    end

    assign cmd_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

### design/task_pool_frame_scheduler.sv
// Commands take one item at a time; create and call search upward for the lowest free
// slot, stepping past each occupied slot.
// A tick walks the listed tasks in list order, reading each through the registered slot RAMs.
// Each result beat waits while the output register is stalled.
// Reset is asynchronous and empties the pool; the slot RAMs are not swept.
module task_pool_frame_scheduler #(
    parameter int TASK_SLOTS = 64,
    parameter int WAIT_BITS = 16,
    parameter int ADDR_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  tpfs_pkg::in_t  cmd_item,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output tpfs_pkg::out_t rsp_item
);
    import tpfs_pkg::*;

    cmd_bus_t  cmd;
    stat_bus_t stat;

    tpfs_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .stat(stat),
        .cmd(cmd)
    );

    tpfs_dp #(
        .TASK_SLOTS(TASK_SLOTS),
        .WAIT_BITS(WAIT_BITS),
        .ADDR_BITS(ADDR_BITS)
    ) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .item(cmd_item),
        .cmd(cmd),
        .stat(stat),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_item(rsp_item)
    );
endmodule

### tb/task_pool_frame_scheduler_checker.sv
`timescale 1ns / 100ps

module task_pool_frame_scheduler_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  logic           cmd_stall,
    input  tpfs_pkg::in_t  cmd_item,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  tpfs_pkg::out_t rsp_item,
    output int             pending,
    output int             fail_count
);
    import tpfs_pkg::*;

    localparam int SLOTS = 64;
    localparam int NONE = 64;

    logic        slot_live [SLOTS];
    logic        slot_asleep [SLOTS];
    logic [31:0] slot_handler [SLOTS];
    logic [15:0] slot_wait [SLOTS];
    int          slot_parent [SLOTS];
    int          slot_prev [SLOTS];
    int          slot_next [SLOTS];
    int          run_head;
    int          run_tail;
    out_t        expected_beats [$];

    task automatic empty_run_list();
        run_head = NONE;
        run_tail = NONE;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_live[i] = 1'b0;
            slot_asleep[i] = 1'b0;
            slot_prev[i] = NONE;
            slot_next[i] = NONE;
        end
    endtask

    function automatic int alloc_slot(logic [31:0] addr);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!slot_live[i])
            begin
                slot_live[i] = 1'b1;
                slot_asleep[i] = 1'b0;
                slot_handler[i] = addr;
                slot_parent[i] = NONE;
                if (run_head == NONE || run_tail == NONE)
                begin
                    run_head = i;
                    slot_prev[i] = NONE;
                end
                else
                begin
                    slot_next[run_tail] = i;
                    slot_prev[i] = run_tail;
                end
                slot_next[i] = NONE;
                run_tail = i;
                return i;
            end
        end
        return NONE;
    endfunction

    task automatic unlink_slot(int s);
        int p;
        int n;
        slot_live[s] = 1'b0;
        p = slot_prev[s];
        n = slot_next[s];
        if (p == NONE && n == NONE)
        begin
            empty_run_list();
            return;
        end
        if (p == NONE)
            run_head = n;
        else
            slot_next[p] = n;
        if (n == NONE)
            run_tail = p;
        else
            slot_prev[n] = p;
    endtask

    task automatic push_ack(logic [1:0] st, int tslot);
        out_t r;
        r = '0;
        r.kind = KIND_ACK;
        r.task_slot = tslot[SLOT_W-1:0];
        r.status = st;
        r.last = 1'b1;
        expected_beats.push_back(r);
    endtask

    task automatic predict_command(in_t it);
        int   s;
        int   c;
        int   steps;
        int   n;
        logic live;
        out_t r;
        s = it.slot;
        live = slot_live[s];
        case (it.op)
            OP_INIT:
            begin
                empty_run_list();
                push_ack(ST_OK, 0);
            end
            OP_CREATE:
            begin
                c = alloc_slot(it.entry_addr);
                if (c == NONE)
                    push_ack(ST_NO_FREE, 0);
                else
                    push_ack(ST_OK, c);
            end
            OP_KILL:
            begin
                if (!live)
                    push_ack(ST_NOT_USED, 0);
                else
                begin
                    unlink_slot(s);
                    push_ack(ST_OK, 0);
                end
            end
            OP_CALL:
            begin
                if (!live)
                    push_ack(ST_NOT_USED, 0);
                else
                begin
                    c = alloc_slot(it.entry_addr);
                    if (c == NONE)
                        push_ack(ST_NO_FREE, 0);
                    else
                    begin
                        slot_parent[c] = s;
                        slot_asleep[s] = 1'b1;
                        push_ack(ST_OK, c);
                    end
                end
            end
            OP_RETURN:
            begin
                if (!live)
                    push_ack(ST_NOT_USED, 0);
                else
                begin
                    c = slot_parent[s];
                    if (c != NONE && slot_live[c])
                        slot_asleep[c] = 1'b0;
                    unlink_slot(s);
                    push_ack(ST_OK, 0);
                end
            end
            OP_SET_WAIT:
            begin
                slot_wait[s] = it.wait_time;
                push_ack(ST_OK, 0);
            end
            OP_SLEEP, OP_WAKEUP:
            begin
                if (!live)
                    push_ack(ST_NOT_USED, 0);
                else
                begin
                    slot_asleep[s] = (it.op == OP_SLEEP);
                    push_ack(ST_OK, 0);
                end
            end
            OP_TICK:
            begin
                n = 0;
                steps = 0;
                c = run_head;
                while (c != NONE && steps < SLOTS)
                begin
                    if (!slot_asleep[c])
                    begin
                        if (slot_wait[c] > 16'd1)
                            slot_wait[c] = slot_wait[c] - 16'd1;
                        else if (n < RESULT_CAP)
                        begin
                            r = '0;
                            r.kind = KIND_DISPATCH;
                            r.task_slot = c[SLOT_W-1:0];
                            r.handler = slot_handler[c];
                            r.status = ST_OK;
                            r.dispatch_valid = 1'b1;
                            expected_beats.push_back(r);
                            n++;
                        end
                    end
                    c = slot_next[c];
                    steps++;
                end
                if (n == 0)
                    push_ack(ST_OK, 0);
                else
                    expected_beats[expected_beats.size() - 1].last = 1'b1;
            end
            default:
                push_ack(ST_OK, 0);
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_handler[i] = '0;
                slot_wait[i] = '0;
                slot_parent[i] = NONE;
            end
            empty_run_list();
            expected_beats.delete();
            fail_count = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_beats.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    $display("%0t: unexpected beat, expected none, actual %p",
                             $time, rsp_item);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (rsp_item.kind !== want.kind
                        || rsp_item.task_slot !== want.task_slot
                        || rsp_item.handler !== want.handler
                        || rsp_item.status !== want.status
                        || rsp_item.dispatch_valid !== want.dispatch_valid
                        || rsp_item.last !== want.last)
                    begin
                        fail_count = fail_count + 1;
                        $display("%0t: mismatch, expected %p, actual %p",
                                 $time, want, rsp_item);
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
                predict_command(cmd_item);
        end
        pending = expected_beats.size();
    end

endmodule

### tb/task_pool_frame_scheduler_tb.sv
`timescale 1ns / 100ps

module task_pool_frame_scheduler_tb;
    import tpfs_pkg::*;

    localparam int ITEMS = 210;
    localparam int IDLE_LIMIT = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    in_t  cmd_item = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    out_t rsp_item;
    int   pending;
    int   fail_count;
    int   sent = 0;
    int   idle_cycles = 0;
    int   rsp_hold = 0;
    logic quiet = 1'b0;

    always #4 clk = ~clk;

    task_pool_frame_scheduler dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd_item(cmd_item),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_item(rsp_item)
    );

    task_pool_frame_scheduler_checker checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd_item(cmd_item),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_item(rsp_item),
        .pending(pending),
        .fail_count(fail_count)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_hold > 0)
            begin
                rsp_hold <= rsp_hold - 1;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
                if (rsp_valid && !rsp_stall && !quiet)
                    rsp_hold <= $urandom_range(0, 16);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("task_pool_frame_scheduler_tb failed");
            $finish;
        end
    end

    task automatic send(logic [3:0] op, int s, logic [31:0] addr, logic [15:0] wt);
        in_t it;
        int  gap;
        it.op = op;
        it.slot = s[SLOT_W-1:0];
        it.entry_addr = addr;
        it.wait_time = wt;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item <= it;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic int pick_slot();
        if ($urandom_range(0, 9) < 3)
            return $urandom_range(0, 63);
        return $urandom_range(0, 15);
    endfunction

    function automatic logic [15:0] pick_wait();
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom());
        return 16'($urandom_range(0, 3));
    endfunction

    initial
    begin
        int w;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Free-slot and empty-list corners, then a call and return chain.
        send(OP_TICK, 0, 0, 0);
        send(OP_KILL, 0, 0, 0);
        send(OP_RETURN, 5, 0, 0);
        send(OP_SLEEP, 63, 0, 0);
        send(OP_WAKEUP, 63, 0, 0);
        send(OP_CALL, 3, 32'h1234, 0);
        send(OP_SET_WAIT, 63, 0, 16'hffff);
        send(OP_SET_WAIT, 63, 0, 16'h0000);
        send(OP_CREATE, 0, 32'hffffffff, 0);
        send(OP_CREATE, 0, 32'h00000000, 0);
        send(OP_CALL, 0, 32'ha5a5a5a5, 0);
        send(OP_SET_WAIT, 2, 0, 16'd2);
        send(OP_TICK, 0, 0, 0);
        send(OP_TICK, 0, 0, 0);
        send(OP_RETURN, 2, 0, 0);
        send(OP_SLEEP, 1, 0, 0);
        send(OP_TICK, 0, 0, 0);
        send(OP_WAKEUP, 1, 0, 0);
        send(OP_RETURN, 1, 0, 0);
        send(4'd15, 0, 0, 0);
        send(4'd9, 7, 0, 0);
        send(OP_KILL, 0, 0, 0);
        send(OP_CREATE, 0, 32'h55aa55aa, 0);
        send(OP_CALL, 0, 32'haa55aa55, 0);
        send(OP_KILL, 0, 0, 0);
        send(OP_RETURN, 1, 0, 0);
        send(OP_INIT, 0, 0, 0);

        // Fill the whole pool, overflow it, and dispatch every slot in one frame.
        quiet = 1'b1;
        for (int i = 0; i < 64; i++)
            send(OP_CREATE, 0, $urandom(), 0);
        quiet = 1'b0;
        send(OP_CREATE, 0, $urandom(), 0);
        send(OP_CALL, 10, $urandom(), 0);
        send(OP_TICK, 0, 0, 0);
        drain();

        while (sent < ITEMS)
        begin
            if (sent % 30 == 0)
                quiet = $urandom_range(0, 2) == 0;
            if (sent == 150)
                drain();
            w = $urandom_range(0, 99);
            if (w < 20)
                send(OP_CREATE, 0, $urandom(), 0);
            else if (w < 32)
                send(OP_CALL, pick_slot(), $urandom(), 0);
            else if (w < 42)
                send(OP_KILL, pick_slot(), 0, 0);
            else if (w < 52)
                send(OP_RETURN, pick_slot(), 0, 0);
            else if (w < 62)
                send(OP_SET_WAIT, pick_slot(), 0, pick_wait());
            else if (w < 69)
                send(OP_SLEEP, pick_slot(), 0, 0);
            else if (w < 76)
                send(OP_WAKEUP, pick_slot(), 0, 0);
            else if (w < 96)
                send(OP_TICK, pick_slot(), $urandom(), 16'($urandom()));
            else if (w < 98)
                send(OP_INIT, 0, 0, 0);
            else
                send(4'($urandom_range(9, 15)), pick_slot(), $urandom(), 16'($urandom()));
        end
        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("task_pool_frame_scheduler_tb passed");
        else
            $display("task_pool_frame_scheduler_tb failed");
        $finish;
    end

endmodule
